@@ rtl/dlw_pkg.sv @@
// Shared types and constants of the detection to world coordinate block.
`default_nettype none
package dlw_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SENSOR_WIDTH  = 3'd0,
        CFG_SENSOR_HEIGHT = 3'd1,
        CFG_IMAGE_WIDTH   = 3'd2,
        CFG_IMAGE_HEIGHT  = 3'd3,
        CFG_MPP_X         = 3'd4,
        CFG_MPP_Y         = 3'd5
    } cfg_index_t;

    localparam logic [13:0] RST_SENSOR_WIDTH  = 14'd1920;
    localparam logic [13:0] RST_SENSOR_HEIGHT = 14'd1080;
    localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd640;
    localparam logic [23:0] RST_MPP           = 24'd65536;

    localparam logic [16:0] SIN_A_Q = 17'd51472;
    localparam logic [15:0] SIN_B = 16'd21023;
    localparam logic [11:0] SIN_C = 12'd2320;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    localparam logic [46:0] VS_LIMIT = 47'h3FFF_FFFF_FFFF;

    localparam logic signed [50:0] SAT_MAX = 51'sd2147483647;
    localparam logic signed [50:0] SAT_MIN = -51'sd2147483648;

    typedef struct packed {
        logic        [7:0]  label;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic        [1:0]  quad;
        logic        [15:0] t;
    } side_t;

    typedef struct packed {
        logic        [7:0]  label;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/dlw_if.sv @@
// Stream interfaces for detection items and world coordinate items.
`default_nettype none
interface dlw_in_if #(
    parameter int PIXEL_BITS = 12,
    parameter int ANGLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic        [PIXEL_BITS-1:0] box_left;
    logic        [PIXEL_BITS-1:0] box_top;
    logic        [PIXEL_BITS-1:0] box_width;
    logic        [PIXEL_BITS-1:0] box_height;
    logic        [7:0]            class_label;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [31:0]           origin_x;
    logic signed [31:0]           origin_y;

    modport source (
        output valid, box_left, box_top, box_width, box_height,
               class_label, yaw_angle, origin_x, origin_y,
        input  ready
    );
    modport sink (
        input  valid, box_left, box_top, box_width, box_height,
               class_label, yaw_angle, origin_x, origin_y,
        output ready
    );
endinterface

interface dlw_out_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  object_label;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;

    modport source (
        output valid, object_label, world_x, world_y,
        input  ready
    );
    modport sink (
        input  valid, object_label, world_x, world_y,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/dlw_div_cell.sv @@
// One restoring division step: shift in a dividend bit, trial subtract, emit a quotient bit.
`default_nettype none
module dlw_div_cell #(
    parameter int DW = 43
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [12:0]   divisor,
    input  wire logic [12:0]   rem_in,
    input  wire logic [DW-1:0] dq_in,
    output logic      [12:0]   rem_out,
    output logic      [DW-1:0] dq_out
);

    logic [13:0] trial;
    logic        ge;
    logic [13:0] diff;

    always_comb
    begin
        trial = {rem_in, dq_in[DW-1]};
        ge    = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= ge ? diff[12:0] : trial[12:0];
            dq_out  <= {dq_in[DW-2:0], ge};
        end
    end

endmodule
`default_nettype wire

@@ rtl/dlw_sine.sv @@
// Four-stage quarter-wave sine polynomial in Q1.15.
`default_nettype none
module dlw_sine (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] t_in,
    output logic      [15:0] s_out
);

    logic [15:0] s1_t_reg, s1_t2_reg;
    logic [15:0] s2_t_reg, s2_t2_reg, s2_u_reg;
    logic [15:0] s3_t_reg;
    logic [16:0] s3_v_reg;
    logic [15:0] s4_s_reg;

    logic [31:0] p1;
    logic [27:0] p2;
    logic [31:0] p3;
    logic [32:0] p4;
    logic [17:0] s_raw;

    always_comb
    begin
        p1    = 32'(t_in) * 32'(t_in);
        p2    = 28'(dlw_pkg::SIN_C) * 28'(s1_t2_reg);
        p3    = 32'(s2_u_reg) * 32'(s2_t2_reg);
        p4    = 33'(s3_v_reg) * 33'(s3_t_reg);
        s_raw = p4[32:15];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_t_reg  <= t_in;
            s1_t2_reg <= p1[30:15];
            s2_t_reg  <= s1_t_reg;
            s2_t2_reg <= s1_t2_reg;
            s2_u_reg  <= dlw_pkg::SIN_B - 16'(p2[27:15]);
            s3_t_reg  <= s2_t_reg;
            s3_v_reg  <= dlw_pkg::SIN_A_Q - p3[31:15];
            s4_s_reg  <= (s_raw > 18'(dlw_pkg::ONE_Q15)) ? dlw_pkg::ONE_Q15 : s_raw[15:0];
        end
    end

    assign s_out = s4_s_reg;

endmodule
`default_nettype wire

@@ rtl/detection_to_local_world_coords_top.sv @@
// Throughput: one item per cycle unless the output queue is full; the pipeline advances as one under a single enable.
// The quotient chain holds PIXEL_BITS + 31 division cells, one bit each.
// A two-entry output queue lets the pipeline run on while one result waits.
// Reset: configuration takes its defaults, all stage valids and the queue clear.
`default_nettype none
module detection_to_local_world_coords_top #(
    parameter int PIXEL_BITS = 12,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [dlw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dlw_pkg::CFG_DATA_W-1:0]   cfg_data,
    dlw_in_if.sink                                det,
    dlw_out_if.source                             res
);

    localparam int DW = PIXEL_BITS + 31;
    localparam int NQ = DW;
    localparam int NS = NQ + 7;
    localparam int QB = ANGLE_BITS - 2;

    logic [13:0] sw_reg, sh_reg;
    logic [12:0] iw_reg, ih_reg;
    logic [23:0] mx_reg, my_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= dlw_pkg::RST_SENSOR_WIDTH;
            sh_reg <= dlw_pkg::RST_SENSOR_HEIGHT;
            iw_reg <= dlw_pkg::RST_IMAGE_WIDTH;
            ih_reg <= dlw_pkg::RST_IMAGE_HEIGHT;
            mx_reg <= dlw_pkg::RST_MPP;
            my_reg <= dlw_pkg::RST_MPP;
        end
        else if (cfg_we)
        begin
            case (dlw_pkg::cfg_index_t'(cfg_index))
                dlw_pkg::CFG_SENSOR_WIDTH:  sw_reg <= cfg_data[13:0];
                dlw_pkg::CFG_SENSOR_HEIGHT: sh_reg <= cfg_data[13:0];
                dlw_pkg::CFG_IMAGE_WIDTH:   iw_reg <= cfg_data[12:0];
                dlw_pkg::CFG_IMAGE_HEIGHT:  ih_reg <= cfg_data[12:0];
                dlw_pkg::CFG_MPP_X:         mx_reg <= cfg_data;
                dlw_pkg::CFG_MPP_Y:         my_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                    en;
    logic [NS-1:0]           vld_reg;
    logic [1:0]              cnt_reg;
    logic                    wr_ptr_reg, rd_ptr_reg;
    dlw_pkg::result_t        buf_reg [2];
    logic                    push, pop;
    dlw_pkg::result_t        res_next;

    assign en        = cnt_reg != 2'd2;
    assign det.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], det.valid};
    end

    // stage 0: centres, numerators, phase
    logic [PIXEL_BITS:0]  cx, cy;
    logic [QB-1:0]        frac;
    logic [15:0]          t_a;
    dlw_pkg::side_t       side_reg [NS];

    assign cx   = {1'b0, det.box_left} + {2'b0, det.box_width[PIXEL_BITS-1:1]};
    assign cy   = {1'b0, det.box_top} + {2'b0, det.box_height[PIXEL_BITS-1:1]};
    assign frac = det.yaw_angle[QB-1:0];

    generate
        if (QB <= 15)
        begin : g_t_up
            assign t_a = 16'(frac) << (15 - QB);
        end
        else
        begin : g_t_dn
            assign t_a = 16'(frac >> (QB - 15));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].label    <= det.class_label;
            side_reg[0].origin_x <= det.origin_x;
            side_reg[0].origin_y <= det.origin_y;
            side_reg[0].quad     <= det.yaw_angle[ANGLE_BITS-1:ANGLE_BITS-2];
            side_reg[0].t        <= t_a;
            for (int i = 1; i < NS; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    logic        [PIXEL_BITS:0] cen  [2];
    logic        [13:0]         sens [2];
    logic        [12:0]         img  [2];
    logic        [23:0]         mpp  [2];
    logic signed [46:0]         v_reg [2];

    assign cen[0]  = cx;
    assign cen[1]  = cy;
    assign sens[0] = sw_reg;
    assign sens[1] = sh_reg;
    assign img[0]  = iw_reg;
    assign img[1]  = ih_reg;
    assign mpp[0]  = mx_reg;
    assign mpp[1]  = my_reg;

    generate
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [PIXEL_BITS+14:0] num_reg;
            logic [12:0]            divisor;
            logic [12:0]            rem_w [NQ+1];
            logic [DW-1:0]          dq_w  [NQ+1];
            logic signed [DW:0]     p;
            logic [DW-1:0]          m_reg;
            logic                   n1_reg, n2_reg, n3_reg;
            logic [39:0]            lo_reg;
            logic [DW+7:0]          hi_reg;
            logic [DW+8:0]          q3_reg;
            logic                   fz_reg;
            logic [DW+9:0]          mag;
            logic [46:0]            magc;

            assign divisor = (img[l] == 13'd0) ? 13'd1 : img[l];

            always_ff @(posedge clk)
            begin
                if (en)
                    num_reg <= (PIXEL_BITS+15)'(cen[l]) * (PIXEL_BITS+15)'(sens[l]);
            end

            assign rem_w[0] = '0;
            assign dq_w[0]  = {num_reg, 16'b0};

            for (genvar c = 0; c < NQ; c++)
            begin : g_cell
                dlw_div_cell #(.DW(DW)) u_cell (
                    .clk     (clk),
                    .en      (en),
                    .divisor (divisor),
                    .rem_in  (rem_w[c]),
                    .dq_in   (dq_w[c]),
                    .rem_out (rem_w[c+1]),
                    .dq_out  (dq_w[c+1])
                );
            end

            assign p = $signed({1'b0, dq_w[NQ]})
                     - $signed({{(DW-28){1'b0}}, sens[l], 15'b0});

            always_comb
            begin
                mag  = (DW+10)'(q3_reg) + (DW+10)'(n3_reg & fz_reg);
                magc = (mag > (DW+10)'(dlw_pkg::VS_LIMIT)) ? dlw_pkg::VS_LIMIT : mag[46:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n1_reg   <= p[DW];
                    m_reg    <= p[DW] ? DW'(-p) : DW'(p);
                    n2_reg   <= n1_reg;
                    lo_reg   <= 40'(m_reg[15:0]) * 40'(mpp[l]);
                    hi_reg   <= (DW+8)'(m_reg[DW-1:16]) * (DW+8)'(mpp[l]);
                    n3_reg   <= n2_reg;
                    q3_reg   <= (DW+9)'(hi_reg) + (DW+9)'(lo_reg[39:16]);
                    fz_reg   <= lo_reg[15:0] != 16'd0;
                    v_reg[l] <= n3_reg ? -$signed(magc) : $signed(magc);
                end
            end
        end
    endgenerate

    logic [15:0]        t0, t1, s0, s1;
    logic signed [16:0] sn, cs;

    assign t0 = side_reg[NQ].t;
    assign t1 = dlw_pkg::ONE_Q15 - t0;

    dlw_sine u_sine0 (.clk(clk), .en(en), .t_in(t0), .s_out(s0));
    dlw_sine u_sine1 (.clk(clk), .en(en), .t_in(t1), .s_out(s1));

    always_comb
    begin
        case (side_reg[NQ+4].quad)
            2'd0:
            begin
                sn = $signed({1'b0, s0});
                cs = $signed({1'b0, s1});
            end
            2'd1:
            begin
                sn = $signed({1'b0, s1});
                cs = -$signed({1'b0, s0});
            end
            2'd2:
            begin
                sn = -$signed({1'b0, s0});
                cs = -$signed({1'b0, s1});
            end
            default:
            begin
                sn = -$signed({1'b0, s1});
                cs = $signed({1'b0, s0});
            end
        endcase
    end

    logic signed [63:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [64:0] dx, dy;
    logic signed [49:0] rx_reg, ry_reg;

    assign dx = 65'(pxc_reg) - 65'(pys_reg);
    assign dy = 65'(pxs_reg) + 65'(pyc_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxc_reg <= 64'(v_reg[0]) * 64'(cs);
            pys_reg <= 64'(v_reg[1]) * 64'(sn);
            pxs_reg <= 64'(v_reg[0]) * 64'(sn);
            pyc_reg <= 64'(v_reg[1]) * 64'(cs);
            rx_reg  <= 50'(dx >>> 15);
            ry_reg  <= 50'(dy >>> 15);
        end
    end

    logic signed [50:0] sum_x, sum_y;

    always_comb
    begin
        sum_x = 51'(side_reg[NS-1].origin_x) + 51'(rx_reg);
        sum_y = 51'(side_reg[NS-1].origin_y) + 51'(ry_reg);
        res_next.label   = side_reg[NS-1].label;
        res_next.world_x = (sum_x > dlw_pkg::SAT_MAX) ? 32'sh7FFF_FFFF :
                           (sum_x < dlw_pkg::SAT_MIN) ? 32'sh8000_0000 : 32'(sum_x);
        res_next.world_y = (sum_y > dlw_pkg::SAT_MAX) ? 32'sh7FFF_FFFF :
                           (sum_y < dlw_pkg::SAT_MIN) ? 32'sh8000_0000 : 32'(sum_y);
    end

    assign push = en && vld_reg[NS-1];
    assign pop  = (cnt_reg != 2'd0) && res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= res_next;
    end

    assign res.valid        = cnt_reg != 2'd0;
    assign res.object_label = buf_reg[rd_ptr_reg].label;
    assign res.world_x      = buf_reg[rd_ptr_reg].world_x;
    assign res.world_y      = buf_reg[rd_ptr_reg].world_y;

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !det.ready)
        else $error("input taken while output queue full");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (det.valid && det.ready) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && !en) |=> vld_reg[NS-1])
        else $error("last stage item dropped during stall");

    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg != 2'd0))
        else $error("pushed item lost from output queue");

    a_sine: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NQ+4] |-> ((s0 <= dlw_pkg::ONE_Q15) && (s1 <= dlw_pkg::ONE_Q15)))
        else $error("sine out of range");

endmodule
`default_nettype wire
